/* rtl/chunked_bitmap_block_pool_macros.svh */
// assertion macros for the block pool checker
`ifndef CHUNKED_BITMAP_BLOCK_POOL_MACROS_SVH
`define CHUNKED_BITMAP_BLOCK_POOL_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define CBBP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("block pool check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define CBBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("block pool check failed");

`endif

/* rtl/cbbp_pkg.sv */
// shared constants, status codes and command type for the block pool
package cbbp_pkg;

  localparam int BLOCKS_PER_CHUNK = 256;
  localparam int BLOCK_BYTES      = 64;
  localparam int MAX_CHUNKS       = 16;

  localparam int ADDR_W  = 18;
  localparam int OFS_W   = $clog2(BLOCK_BYTES);
  localparam int BLK_W   = $clog2(BLOCKS_PER_CHUNK);
  localparam int CHUNK_W = $clog2(MAX_CHUNKS);
  localparam int OPEN_W  = 5;

  // bitmap search is split into groups
  localparam int GRP_W     = 16;
  localparam int GRPS      = BLOCKS_PER_CHUNK / GRP_W;
  localparam int GRP_IDX_W = $clog2(GRPS);
  localparam int GRP_BIT_W = $clog2(GRP_W);

  localparam logic [1:0] ST_ALLOC   = 2'd0;
  localparam logic [1:0] ST_FREED   = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic latch;   // capture the accepted request
    logic rd;      // read bitmap of the target chunk
    logic search;  // capture bitmap and group summaries
    logic commit;  // write back and load the result
  } cmd_t;

endpackage

/* rtl/chunked_bitmap_block_pool.sv */
// Chunked bitmap block pool allocator: each request is an allocate (lowest free
// 64-byte block of the newest open 256-block chunk, opening the next chunk of
// sixteen when none is open or that one is full, no-space status once all are
// full) or a free (byte address rounded down to its block). A free outside the
// opened chunks or of a block already free returns the invalid status and
// changes nothing. After a request is accepted, the sequencer issues the read of
// the chunk's bitmap memory, then takes its registered read data and the first
// level of the lowest-free search, then finishes the search and writes the
// bitmap back. It then returns to idle, so a new request is accepted only once
// the previous one has been written back. The result sits in an output register;
// a new request is accepted even while the previous result still waits, and its
// write-back is held for as long as that earlier result is not taken.
// No clearing pass after reset.
module chunked_bitmap_block_pool (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [cbbp_pkg::ADDR_W-1:0] in_byte_address,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [cbbp_pkg::ADDR_W-1:0] out_block_address,
  output logic [cbbp_pkg::OPEN_W-1:0] out_chunks_open
);

  cbbp_pkg::cmd_t cmd;

  // sequencer: idle, read, search, commit
  cbbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // bitmap store, search and result registers
  cbbp_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_action         (in_action),
    .in_byte_address   (in_byte_address),
    .out_status        (out_status),
    .out_block_address (out_block_address),
    .out_chunks_open   (out_chunks_open)
  );

endmodule

/* rtl/cbbp_ram.sv */
// generic single-write, single-read ram with registered read data
module cbbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/cbbp_ctrl.sv */
// request sequencer and result handshake for the block pool
module cbbp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output cbbp_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    cmd.latch  = in_valid && in_ready;
    cmd.rd     = (state_r == S_RD);
    cmd.search = (state_r == S_SRCH);
    cmd.commit = (state_r == S_FIN) && slot_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_RD;
      S_RD:   state_nxt = S_SRCH;
      S_SRCH: state_nxt = S_FIN;
      S_FIN:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/cbbp_dpath.sv */
// bitmap memory, lowest-free search, update and result registers
module cbbp_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cbbp_pkg::cmd_t                cmd,
  input  logic                          in_action,
  input  logic [cbbp_pkg::ADDR_W-1:0]   in_byte_address,
  output logic [1:0]                    out_status,
  output logic [cbbp_pkg::ADDR_W-1:0]   out_block_address,
  output logic [cbbp_pkg::OPEN_W-1:0]   out_chunks_open
);

  localparam int BPC     = cbbp_pkg::BLOCKS_PER_CHUNK;
  localparam int ADDR_W  = cbbp_pkg::ADDR_W;
  localparam int OFS_W   = cbbp_pkg::OFS_W;
  localparam int BLK_W   = cbbp_pkg::BLK_W;
  localparam int CHUNK_W = cbbp_pkg::CHUNK_W;
  localparam int OPEN_W  = cbbp_pkg::OPEN_W;
  localparam int GRP_W   = cbbp_pkg::GRP_W;
  localparam int GRPS    = cbbp_pkg::GRPS;
  localparam int GIDX_W  = cbbp_pkg::GRP_IDX_W;
  localparam int GBIT_W  = cbbp_pkg::GRP_BIT_W;

  logic                act_r;
  logic [CHUNK_W-1:0]  chunk_r;
  logic [BLK_W-1:0]    blk_r;
  logic [OPEN_W-1:0]   open_r, open_nxt;
  logic [BPC-1:0]      word_r;
  logic [GRPS-1:0]     grp_any_r;
  logic [GBIT_W-1:0]   grp_first_r [GRPS];
  logic [GBIT_W-1:0]   grp_first   [GRPS];

  logic [1:0]          status_r, status_nxt;
  logic [ADDR_W-1:0]   baddr_r, baddr_nxt;
  logic [OPEN_W-1:0]   copen_r;

  logic [BPC-1:0]      ram_rdata, ram_wdata;
  logic [CHUNK_W-1:0]  ram_raddr, ram_waddr;
  logic                wr_want;

  logic [CHUNK_W-1:0]  newest;
  logic [GIDX_W-1:0]   pick_g;
  logic [BLK_W-1:0]    pick_idx;
  logic [BPC-1:0]      pick_mask, free_mask;

  cbbp_ram #(
    .WIDTH (BPC),
    .DEPTH (cbbp_pkg::MAX_CHUNKS)
  ) u_map (
    .clk   (clk),
    .we    (cmd.commit && wr_want),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign newest      = open_r[CHUNK_W-1:0] - CHUNK_W'(1);
  assign ram_raddr   = (act_r == cbbp_pkg::ACT_FREE) ? chunk_r : newest;

  // first set bit within each group of the fetched bitmap
  always_comb begin
    for (int g = 0; g < GRPS; g++) begin
      grp_first[g] = '0;
      for (int b = GRP_W - 1; b >= 0; b--) begin
        if (ram_rdata[g*GRP_W + b]) grp_first[g] = GBIT_W'(b);
      end
    end
  end

  // lowest group holding a free block
  always_comb begin
    pick_g = '0;
    for (int g = GRPS - 1; g >= 0; g--) begin
      if (grp_any_r[g]) pick_g = GIDX_W'(g);
    end
  end

  assign pick_idx  = {pick_g, grp_first_r[pick_g]};
  assign pick_mask = BPC'(1) << pick_idx;
  assign free_mask = BPC'(1) << blk_r;

  always_comb begin
    status_nxt = cbbp_pkg::ST_INVALID;
    baddr_nxt  = '0;
    open_nxt   = open_r;
    wr_want    = 1'b0;
    ram_waddr  = chunk_r;
    ram_wdata  = word_r | free_mask;
    if (act_r == cbbp_pkg::ACT_ALLOC) begin
      if (open_r == '0 || word_r == '0) begin
        if (open_r == OPEN_W'(cbbp_pkg::MAX_CHUNKS)) begin
          status_nxt = cbbp_pkg::ST_NOSPACE;
        end else begin
          // open the next chunk and hand out its block zero
          status_nxt = cbbp_pkg::ST_ALLOC;
          wr_want    = 1'b1;
          ram_waddr  = open_r[CHUNK_W-1:0];
          ram_wdata  = {{(BPC-1){1'b1}}, 1'b0};
          baddr_nxt  = {open_r[CHUNK_W-1:0], {BLK_W{1'b0}}, {OFS_W{1'b0}}};
          open_nxt   = open_r + OPEN_W'(1);
        end
      end else begin
        status_nxt = cbbp_pkg::ST_ALLOC;
        wr_want    = 1'b1;
        ram_waddr  = newest;
        ram_wdata  = word_r & ~pick_mask;
        baddr_nxt  = {newest, pick_idx, {OFS_W{1'b0}}};
      end
    end else begin
      if (OPEN_W'(chunk_r) < open_r && !word_r[blk_r]) begin
        status_nxt = cbbp_pkg::ST_FREED;
        wr_want    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
    end else if (cmd.commit) begin
      open_r <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r   <= in_action;
      chunk_r <= in_byte_address[OFS_W+BLK_W +: CHUNK_W];
      blk_r   <= in_byte_address[OFS_W +: BLK_W];
    end
    if (cmd.search) begin
      word_r <= ram_rdata;
      for (int g = 0; g < GRPS; g++) begin
        grp_any_r[g]   <= |ram_rdata[g*GRP_W +: GRP_W];
        grp_first_r[g] <= grp_first[g];
      end
    end
    if (cmd.commit) begin
      status_r <= status_nxt;
      baddr_r  <= baddr_nxt;
      copen_r  <= open_nxt;
    end
  end

  assign out_status        = status_r;
  assign out_block_address = baddr_r;
  assign out_chunks_open   = copen_r;

endmodule

/* rtl/cbbp_chk.sv */
// port-level checks for the block pool, bound to the top level
`include "chunked_bitmap_block_pool_macros.svh"

module cbbp_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_status,
  input logic [cbbp_pkg::ADDR_W-1:0] out_block_address,
  input logic [cbbp_pkg::OPEN_W-1:0] out_chunks_open
);

  `CBBP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_block_address) && $stable(out_status))
  `CBBP_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `CBBP_ASSERT_NOW(a_addr_zero, out_valid && out_status != cbbp_pkg::ST_ALLOC, out_block_address == '0)
  `CBBP_ASSERT_NOW(a_open_bound, out_valid, out_chunks_open <= cbbp_pkg::OPEN_W'(cbbp_pkg::MAX_CHUNKS))
  `CBBP_ASSERT_NOW(a_alloc_open, out_valid && out_status == cbbp_pkg::ST_ALLOC, out_chunks_open != '0)

endmodule

bind chunked_bitmap_block_pool cbbp_chk u_cbbp_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_block_address (out_block_address),
  .out_chunks_open   (out_chunks_open)
);

/* sim/chunked_bitmap_block_pool_tb.sv */
// self-checking testbench for the chunked bitmap block pool
`timescale 1ns / 1ps

module chunked_bitmap_block_pool_tb;

  localparam int BLOCKS_PER_CHUNK = cbbp_pkg::BLOCKS_PER_CHUNK;
  localparam int BLOCK_BYTES      = cbbp_pkg::BLOCK_BYTES;
  localparam int MAX_CHUNKS       = cbbp_pkg::MAX_CHUNKS;
  localparam int ADDR_W           = cbbp_pkg::ADDR_W;
  localparam int OPEN_W           = cbbp_pkg::OPEN_W;

  localparam int CHUNK_BYTES  = BLOCKS_PER_CHUNK * BLOCK_BYTES;
  localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
  localparam int SETTLE       = 20;       // quiet cycles after the last reply
  localparam int RANDOM_ITEMS = 750;
  localparam int CYCLE_LIMIT  = 500000;

  // one reply of the pool, as seen on the result channel
  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] block_address;
    logic [OPEN_W-1:0] chunks_open;
  } pool_reply_t;

  // pool predictor plus the queue of replies still owed by the block
  class block_pool_scoreboard;
    bit [BLOCKS_PER_CHUNK-1:0] free_bits [MAX_CHUNKS];
    int unsigned               blocks_left [MAX_CHUNKS];
    int unsigned               chunks_open_now;
    pool_reply_t               awaited_replies [$];
    bit [ADDR_W-1:0]           held_blocks [$];
    int unsigned               errors;

    function new();
      for (int c = 0; c < MAX_CHUNKS; c++) begin
        free_bits[c]   = '1;
        blocks_left[c] = BLOCKS_PER_CHUNK;
      end
      chunks_open_now = 0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return awaited_replies.size();
    endfunction

    // apply one accepted request to the pool and queue the reply it owes
    function void note_request(input logic act, input logic [ADDR_W-1:0] addr);
      pool_reply_t want;
      int unsigned chunk;
      int unsigned blk;
      int          lowest;
      bit          exhausted;
      want.status        = cbbp_pkg::ST_INVALID;
      want.block_address = '0;
      exhausted          = 1'b0;
      if (act == cbbp_pkg::ACT_ALLOC) begin
        // newest chunk full (or none open yet): open the next one if any left
        if (chunks_open_now == 0 || blocks_left[chunks_open_now-1] == 0) begin
          if (chunks_open_now >= MAX_CHUNKS) begin
            exhausted = 1'b1;
          end else begin
            free_bits[chunks_open_now]   = '1;
            blocks_left[chunks_open_now] = BLOCKS_PER_CHUNK;
            chunks_open_now++;
          end
        end
        if (exhausted) begin
          want.status = cbbp_pkg::ST_NOSPACE;
        end else begin
          chunk  = chunks_open_now - 1;
          lowest = -1;
          for (int b = 0; b < BLOCKS_PER_CHUNK; b++) begin
            if (free_bits[chunk][b]) begin
              lowest = b;
              break;
            end
          end
          free_bits[chunk][lowest] = 1'b0;
          blocks_left[chunk]--;
          want.status        = cbbp_pkg::ST_ALLOC;
          want.block_address = ADDR_W'((chunk * BLOCKS_PER_CHUNK + lowest) * BLOCK_BYTES);
          held_blocks.push_back(want.block_address);
        end
      end else begin
        chunk = addr / CHUNK_BYTES;
        blk   = (addr % CHUNK_BYTES) / BLOCK_BYTES;
        // unopened chunk or block already free: rejected, nothing changes
        if (chunk < chunks_open_now && !free_bits[chunk][blk]) begin
          free_bits[chunk][blk] = 1'b1;
          blocks_left[chunk]++;
          want.status = cbbp_pkg::ST_FREED;
          for (int i = 0; i < held_blocks.size(); i++) begin
            if (held_blocks[i] == ADDR_W'((chunk * BLOCKS_PER_CHUNK + blk) * BLOCK_BYTES)) begin
              held_blocks.delete(i);
              break;
            end
          end
        end
      end
      want.chunks_open = OPEN_W'(chunks_open_now);
      awaited_replies.push_back(want);
    endfunction

    // compare one reply against the oldest one owed
    function void check_reply(input pool_reply_t got);
      pool_reply_t want;
      if (awaited_replies.size() == 0) begin
        $display("%0t: reply with no request waiting, status %0d address %0d chunks %0d",
                 $time, got.status, got.block_address, got.chunks_open);
        errors++;
        return;
      end
      want = awaited_replies.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
      if (got.block_address !== want.block_address) begin
        $display("%0t: block_address mismatch, expected %0d, actual %0d",
                 $time, want.block_address, got.block_address);
        errors++;
      end
      if (got.chunks_open !== want.chunks_open) begin
        $display("%0t: chunks_open mismatch, expected %0d, actual %0d",
                 $time, want.chunks_open, got.chunks_open);
        errors++;
      end
    endfunction
  endclass

  // clock, reset and block ports; the driven inputs are known from time zero
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_action = cbbp_pkg::ACT_ALLOC;
  logic [ADDR_W-1:0] in_byte_address = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_status;
  logic [ADDR_W-1:0] out_block_address;
  logic [OPEN_W-1:0] out_chunks_open;

  // receiver control: the stimulus flips hold_toggle to ask for one long hold-off
  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;
  logic        rx_steady = 1'b0;
  int unsigned rx_hold_left = 0;
  bit          tx_steady = 1'b0;

  block_pool_scoreboard sb = new();

  chunked_bitmap_block_pool u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_byte_address   (in_byte_address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_block_address (out_block_address),
    .out_chunks_open   (out_chunks_open)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure: random idling, a steady stretch, one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_ready    <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (hold_toggle != hold_seen) begin
      hold_seen    <= hold_toggle;
      rx_hold_left <= HOLD_CYCLES - 1;
      out_ready    <= 1'b0;
    end else if (rx_steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 24);
    end
  end

  // every reply taken on the result channel is checked against the predictor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_reply('{status: out_status, block_address: out_block_address,
                       chunks_open: out_chunks_open});
    end
  end

  // runaway guard, counted in clock cycles
  initial begin : watchdog
    int unsigned cycles_run;
    cycles_run = 0;
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("** chunked_bitmap_block_pool: FAILED **");
    $finish;
  end

  // offer one request, with an optional idle gap in front, and hold it until taken
  task automatic send_request(input logic act, input logic [ADDR_W-1:0] addr);
    int unsigned gap;
    gap = 0;
    if (!tx_steady && $urandom_range(99) < 24) begin
      gap = $urandom_range(3, 1);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_byte_address <= addr;
    do @(posedge clk); while (!in_ready);
    sb.note_request(act, addr);
  endtask

  // sender goes quiet until the block has returned every reply it owes
  task automatic wait_for_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // one random request; alloc_pct sets the share of allocates
  task automatic random_request(input int unsigned alloc_pct);
    int unsigned     roll;
    int unsigned     idx;
    int unsigned     chunk;
    logic [ADDR_W-1:0] noise;
    roll  = $urandom_range(99);
    noise = ADDR_W'($urandom());
    if (roll < alloc_pct) begin
      send_request(cbbp_pkg::ACT_ALLOC, noise);
    end else if (roll < alloc_pct + 25 && sb.held_blocks.size() > 0) begin
      // well-formed free of a live block, any byte inside it
      idx = $urandom_range(sb.held_blocks.size() - 1);
      send_request(cbbp_pkg::ACT_FREE,
                   sb.held_blocks[idx] | ADDR_W'($urandom_range(BLOCK_BYTES - 1)));
    end else if (roll < alloc_pct + 35 && sb.chunks_open_now > 0) begin
      // anywhere in an open chunk: mostly a double free
      chunk = $urandom_range(sb.chunks_open_now - 1);
      send_request(cbbp_pkg::ACT_FREE,
                   ADDR_W'(chunk * CHUNK_BYTES + $urandom_range(CHUNK_BYTES - 1)));
    end else begin
      send_request(cbbp_pkg::ACT_FREE, noise);
    end
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pool, lowest-free reuse, double frees, unopened chunks
    send_request(cbbp_pkg::ACT_FREE,  '0);                         // nothing open yet
    send_request(cbbp_pkg::ACT_ALLOC, '0);                         // opens the first chunk
    send_request(cbbp_pkg::ACT_ALLOC, '0);
    send_request(cbbp_pkg::ACT_ALLOC, '0);
    send_request(cbbp_pkg::ACT_FREE,  ADDR_W'(BLOCK_BYTES + 63));  // last byte of block 1
    send_request(cbbp_pkg::ACT_FREE,  ADDR_W'(BLOCK_BYTES));       // double free
    send_request(cbbp_pkg::ACT_FREE,  ADDR_W'(CHUNK_BYTES));       // chunk not open
    send_request(cbbp_pkg::ACT_FREE,  '1);                         // top of address range
    send_request(cbbp_pkg::ACT_FREE,  '0);
    send_request(cbbp_pkg::ACT_FREE,  '0);                         // double free, block 0
    send_request(cbbp_pkg::ACT_ALLOC, '0);                         // lowest free comes back
    send_request(cbbp_pkg::ACT_ALLOC, '1);                         // address ignored
    send_request(cbbp_pkg::ACT_FREE,
                 ADDR_W'((BLOCKS_PER_CHUNK - 1) * BLOCK_BYTES + 5));
    send_request(cbbp_pkg::ACT_FREE,  ADDR_W'(2 * BLOCK_BYTES));
    send_request(cbbp_pkg::ACT_ALLOC, ADDR_W'(18'h15555));
    send_request(cbbp_pkg::ACT_ALLOC, ADDR_W'(18'h2aaaa));
    wait_for_replies();

    // random mix with a steady stretch, a long hold-off and a full drain;
    // allocates outweigh frees so that further chunks get opened
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 150) begin
        rx_steady <= 1'b1;
        tx_steady = 1'b1;
      end
      if (i == 300) begin
        rx_steady <= 1'b0;
        tx_steady = 1'b0;
      end
      if (i == 400) begin
        hold_toggle <= ~hold_toggle;                     // sender keeps offering
      end
      if (i == 550) begin
        wait_for_replies();
      end
      random_request(60);
    end

    wait_for_replies();
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** chunked_bitmap_block_pool: PASSED **");
    end else begin
      $display("** chunked_bitmap_block_pool: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/cbbp_pkg.sv
rtl/cbbp_ram.sv
rtl/cbbp_ctrl.sv
rtl/cbbp_dpath.sv
rtl/chunked_bitmap_block_pool.sv
rtl/cbbp_chk.sv
sim/chunked_bitmap_block_pool_tb.sv
